// ----- hw/rtl/hfe_pkg.sv -----
// Shared types and constants for the header field extractor.
// Used by hfe_scan and header_field_extractor_top; no dependencies.
`timescale 1ns / 1ps

package hfe_pkg;

  // key storage
  localparam int KEY_MAX_BYTES = 32;
  localparam int KEY_BITS      = KEY_MAX_BYTES * 8;

  // result queue depth in the top level
  localparam int Q_DEPTH = 4;

  // characters that steer the scan
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // configuration register indexes
  localparam logic [2:0] REG_KEY_LENGTH  = 3'd0;
  localparam logic [2:0] REG_KEY_BYTES_A = 3'd1;
  localparam logic [2:0] REG_KEY_BYTES_B = 3'd2;
  localparam logic [2:0] REG_KEY_BYTES_C = 3'd3;
  localparam logic [2:0] REG_KEY_BYTES_D = 3'd4;
  localparam logic [2:0] REG_VALUE_LIMIT = 3'd5;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  // scan phases
  typedef enum logic [2:0] {
    PH_MATCH = 3'd0,
    PH_SKIP  = 3'd1,
    PH_SPACE = 3'd2,
    PH_COPY  = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  // one result beat
  typedef struct packed {
    kind_t      kind;
    logic [7:0] value_byte;
  } res_t;

  // results of one input byte, in order r0 then r1
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } scan_out_t;

  // configuration seen by the scanner
  typedef struct packed {
    logic [5:0]          key_length;
    logic [KEY_BITS-1:0] key_bytes;
    logic [7:0]          value_limit;
  } cfg_t;

endpackage

// ----- hw/rtl/hfe_scan.sv -----
// Per-byte scanner: key match, optional space skip, value copy and end reporting.
// Depends on hfe_pkg; holds the scan state, results are combinational.
`timescale 1ns / 1ps

module hfe_scan (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         text_byte,
  input  logic               is_last,
  input  hfe_pkg::cfg_t      cfg,
  output hfe_pkg::scan_out_t res
);
  import hfe_pkg::*;

  phase_t     phase, phase_next;
  logic [5:0] match_position, match_position_next;
  logic [7:0] copied_count, copied_count_next;

  logic [5:0] klen;
  logic [7:0] key_b;
  logic       e_byte, e_end, e_none;

  // active key length, saturated to the key storage
  assign klen  = (cfg.key_length > 6'(KEY_MAX_BYTES)) ? 6'(KEY_MAX_BYTES) : cfg.key_length;
  assign key_b = cfg.key_bytes[{match_position[4:0], 3'b000} +: 8];

  // next state and result flags for one byte
  always_comb begin
    phase_next          = phase;
    match_position_next = match_position;
    copied_count_next   = copied_count;
    e_byte              = 1'b0;
    e_end               = 1'b0;
    e_none              = 1'b0;
    unique case (phase) inside
      PH_MATCH: begin
        if (match_position < klen) begin
          if (text_byte == key_b) begin
            match_position_next = match_position + 6'd1;
          end else if (text_byte == CHAR_LF) begin
            match_position_next = '0;
          end else begin
            phase_next = PH_SKIP;
          end
        end else if (text_byte == CHAR_COLON) begin
          if (cfg.value_limit == 8'd0 || is_last) begin
            e_end      = 1'b1;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_SPACE;
          end
        end else if (text_byte == CHAR_LF) begin
          match_position_next = '0;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (text_byte == CHAR_LF) begin
          phase_next          = PH_MATCH;
          match_position_next = '0;
        end
      end
      PH_SPACE, PH_COPY: begin
        if (phase == PH_SPACE && text_byte == CHAR_SPACE) begin
          phase_next = PH_COPY;
          if (is_last) begin
            e_end      = 1'b1;
            phase_next = PH_DONE;
          end
        end else if (text_byte == CHAR_CR || text_byte == CHAR_LF) begin
          e_end      = 1'b1;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_COPY;
          if (copied_count < cfg.value_limit) begin
            e_byte            = 1'b1;
            copied_count_next = copied_count + 8'd1;
          end
          if (copied_count_next >= cfg.value_limit || is_last) begin
            e_end      = 1'b1;
            phase_next = PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase
    // last byte of the block: report a miss if no value was found, and rearm
    if (is_last) begin
      if (phase_next == PH_MATCH || phase_next == PH_SKIP) begin
        e_none = 1'b1;
      end
      phase_next          = PH_MATCH;
      match_position_next = '0;
      copied_count_next   = '0;
    end
  end

  // pack results: a value byte always comes before an end beat
  always_comb begin
    res.count = {1'b0, e_byte} + {1'b0, e_end} + {1'b0, e_none};
    res.r0.value_byte = e_byte ? text_byte : 8'd0;
    if (e_byte) begin
      res.r0.kind = KIND_BYTE;
    end else if (e_end) begin
      res.r0.kind = KIND_END;
    end else begin
      res.r0.kind = KIND_NONE;
    end
    res.r1.kind       = KIND_END;
    res.r1.value_byte = 8'd0;
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_MATCH;
      match_position <= '0;
      copied_count   <= '0;
    end else if (step) begin
      phase          <= phase_next;
      match_position <= match_position_next;
      copied_count   <= copied_count_next;
    end
  end

  // match position never runs past the key storage
  assert property (@(posedge clk) disable iff (rst)
    match_position <= 6'(KEY_MAX_BYTES))
    else $error("match position beyond key storage");

  // a second result in one step is always the end beat after a value byte
  assert property (@(posedge clk) disable iff (rst)
    step && res.count == 2'd2 |-> res.r0.kind == KIND_BYTE && res.r1.kind == KIND_END)
    else $error("bad result pair");

  // once done, only the last byte of the block leaves the done phase
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE && step && !is_last |=> phase == PH_DONE)
    else $error("left done phase before end of block");

  // in the done phase nothing is reported, not even a miss on the last byte
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE && step |-> res.count == 2'd0)
    else $error("result produced after end of value");

endmodule

// ----- hw/rtl/header_field_extractor_top.sv -----
// Top level of the header field extractor: config registers, input register,
// scanner and result queue. Depends on hfe_pkg and hfe_scan.
`timescale 1ns / 1ps

// Takes one header byte per beat and returns the value of the first line whose
// key matches, one result per beat. A byte is registered on entry and scanned
// from that register when the queue has room; its results are registered in a
// four-entry output queue. Input is taken every cycle while the queue holds at
// most two results; most bytes give zero or one result, the byte that closes a
// value gives up to two (value byte and end), so the sustained rate is one byte
// per cycle, falling to the output rate of one result per cycle when results
// back up. The queue depth and the two-result step set the stall point.
// Registers are written on cfg_wr_en with no read-back.
module header_field_extractor_top (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // is_last
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] value_byte
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wr_data
);
  import hfe_pkg::*;

  // configuration registers
  logic [5:0]  key_length;
  logic [63:0] key_bytes_a, key_bytes_b, key_bytes_c, key_bytes_d;
  logic [7:0]  value_limit;
  cfg_t        cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length  <= 6'd1;
      key_bytes_a <= '0;
      key_bytes_b <= '0;
      key_bytes_c <= '0;
      key_bytes_d <= '0;
      value_limit <= 8'd255;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_KEY_LENGTH:  key_length  <= cfg_wr_data[5:0];
        REG_KEY_BYTES_A: key_bytes_a <= cfg_wr_data;
        REG_KEY_BYTES_B: key_bytes_b <= cfg_wr_data;
        REG_KEY_BYTES_C: key_bytes_c <= cfg_wr_data;
        REG_KEY_BYTES_D: key_bytes_d <= cfg_wr_data;
        REG_VALUE_LIMIT: value_limit <= cfg_wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.key_length  = key_length;
  assign cfg.key_bytes   = {key_bytes_d, key_bytes_c, key_bytes_b, key_bytes_a};
  assign cfg.value_limit = value_limit;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       step;
  logic       pop;
  logic [2:0] q_cnt, q_cnt_next;

  assign step          = in_valid && (q_cnt <= 3'd2);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // scanner
  scan_out_t scan_res;

  hfe_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .text_byte (in_byte),
    .is_last   (in_last),
    .cfg       (cfg),
    .res       (scan_res)
  );

  // result queue, head always at entry 0
  res_t       q [Q_DEPTH];
  res_t       q_next [Q_DEPTH];
  logic [2:0] base;

  assign pop = m_axis_tvalid && m_axis_tready;

  always_comb begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      for (int i = 0; i < Q_DEPTH - 1; i++) begin
        q_next[i] = q[i + 1];
      end
    end
    base       = q_cnt - {2'b00, pop};
    q_cnt_next = base;
    if (step) begin
      if (scan_res.count != 2'd0) begin
        q_next[base[1:0]] = scan_res.r0;
      end
      if (scan_res.count == 2'd2) begin
        q_next[base[1:0] + 2'd1] = scan_res.r1;
      end
      q_cnt_next = base + {1'b0, scan_res.count};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
    end else begin
      q_cnt <= q_cnt_next;
    end
  end

  assign m_axis_tvalid = (q_cnt != 3'd0);
  assign m_axis_tdata  = q[0].value_byte;
  assign m_axis_tuser  = q[0].kind;

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    q_cnt <= 3'(Q_DEPTH))
    else $error("result queue overflow");

  // a drained queue with no new results goes empty
  assert property (@(posedge clk) disable iff (rst)
    q_cnt == 3'd1 && pop && !step |=> !m_axis_tvalid)
    else $error("queue count lost track of pops");

  // a step that gives results makes the queue non-empty next cycle
  assert property (@(posedge clk) disable iff (rst)
    step && scan_res.count != 2'd0 |=> m_axis_tvalid)
    else $error("results of a step were dropped");

endmodule

// ----- tb/header_field_extractor_top_tb.sv -----
// Self-checking testbench for header_field_extractor_top: byte-stream stimulus,
// a scan predictor inside a small scoreboard class, random stalls on both sides.
// Depends on hfe_pkg and the header_field_extractor_top RTL.
`timescale 1ns / 1ps

module header_field_extractor_top_tb;
  import hfe_pkg::*;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_BYTES  = 100;
  localparam int NUM_PHASES   = 14;
  localparam int LONG_VALUE   = 260;

  // indexes past the register map, writes there must have no effect
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // predicts the result beats of the scan and checks the ones seen on the output
  class extract_scoreboard;
    logic [5:0]          key_len;
    logic [KEY_BITS-1:0] key_bytes;
    logic [7:0]          limit;
    phase_t              scan_phase;
    logic [5:0]          match_pos;
    logic [7:0]          copied;
    res_t                pending_values[$];
    int                  errors;

    function new();
      key_len    = 6'd1;
      key_bytes  = '0;
      limit      = 8'd255;
      scan_phase = PH_MATCH;
      match_pos  = '0;
      copied     = '0;
      errors     = 0;
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [63:0] data);
      case (idx)
        REG_KEY_LENGTH:  key_len = data[5:0];
        REG_KEY_BYTES_A: key_bytes[0   +: 64] = data;
        REG_KEY_BYTES_B: key_bytes[64  +: 64] = data;
        REG_KEY_BYTES_C: key_bytes[128 +: 64] = data;
        REG_KEY_BYTES_D: key_bytes[192 +: 64] = data;
        REG_VALUE_LIMIT: limit = data[7:0];
        default: ;
      endcase
    endfunction

    function logic [5:0] active_len();
      return (key_len > KEY_MAX_BYTES) ? 6'(KEY_MAX_BYTES) : key_len;
    endfunction

    function void push_result(input kind_t kind, input logic [7:0] value_byte);
      res_t r;
      r.kind       = kind;
      r.value_byte = value_byte;
      pending_values.push_back(r);
    endfunction

    // one accepted input beat: advance the scan and queue what it yields
    function void note_byte(input logic [7:0] b, input logic last);
      logic [5:0] klen;
      klen = active_len();
      case (scan_phase)
        PH_MATCH: begin
          if (match_pos < klen) begin
            if (b == key_bytes[match_pos*8 +: 8]) match_pos = match_pos + 6'd1;
            else if (b == CHAR_LF) match_pos = '0;
            else scan_phase = PH_SKIP;
          end else if (b == CHAR_COLON) begin
            if (limit == 8'd0 || last) begin
              push_result(KIND_END, 8'h00);
              scan_phase = PH_DONE;
            end else begin
              scan_phase = PH_SPACE;
            end
          end else if (b == CHAR_LF) begin
            match_pos = '0;
          end else begin
            scan_phase = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (b == CHAR_LF) begin
            scan_phase = PH_MATCH;
            match_pos  = '0;
          end
        end
        PH_SPACE, PH_COPY: begin
          if (scan_phase == PH_SPACE && b == CHAR_SPACE) begin
            scan_phase = PH_COPY;
            if (last) begin
              push_result(KIND_END, 8'h00);
              scan_phase = PH_DONE;
            end
          end else if (b == CHAR_CR || b == CHAR_LF) begin
            push_result(KIND_END, 8'h00);
            scan_phase = PH_DONE;
          end else begin
            scan_phase = PH_COPY;
            if (copied < limit) begin
              push_result(KIND_BYTE, b);
              copied = copied + 8'd1;
            end
            if (copied >= limit || last) begin
              push_result(KIND_END, 8'h00);
              scan_phase = PH_DONE;
            end
          end
        end
        default: ;
      endcase
      // last beat of a header block: report a miss if no value was found, then rearm
      if (last) begin
        if (scan_phase == PH_MATCH || scan_phase == PH_SKIP) push_result(KIND_NONE, 8'h00);
        scan_phase = PH_MATCH;
        match_pos  = '0;
        copied     = '0;
      end
    endfunction

    function int pending();
      return pending_values.size();
    endfunction

    task report(input string what);
      errors++;
      if (errors <= 40) $display("ERROR at %0t: %s", $time, what);
    endtask

    task check_result(input kind_t kind, input logic [7:0] value_byte);
      res_t want;
      if (pending_values.size() == 0) begin
        report($sformatf("result with nothing pending: kind %0d byte %02h", kind, value_byte));
        return;
      end
      want = pending_values.pop_front();
      if (kind !== want.kind)
        report($sformatf("kind %0d, wanted %0d", kind, want.kind));
      if (value_byte !== want.value_byte)
        report($sformatf("value byte %02h, wanted %02h", value_byte, want.value_byte));
    endtask

    task finish_check();
      if (pending_values.size() != 0)
        report($sformatf("%0d results never arrived", pending_values.size()));
    endtask
  endclass

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_wr_en     = 1'b0;
  logic [2:0]  cfg_index     = 3'd0;
  logic [63:0] cfg_wr_data   = '0;

  extract_scoreboard sb = new();

  logic [7:0] text_q[$];
  int         burst_left = 0;
  int         bytes_sent = 0;
  bit         hold_req   = 1'b0;
  int         hold_left  = 0;
  int         stall_pct  = 0;
  int         pattern_left = 0;

  header_field_extractor_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("header_field_extractor_top test failed");
    $finish;
  end

  // receiver: own stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 30;
          3: stall_pct = 60;
          default: stall_pct = 90;
        endcase
        pattern_left = $urandom_range(20, 200);
      end else begin
        pattern_left--;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // result beats
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(kind_t'(m_axis_tuser), m_axis_tdata);
  end

  // one input beat, with burst gaps in front of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  // sends text_q as one header block, last marked on the final byte
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // stop offering input until every result is back, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] noise_char();
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] value_char();
    logic [7:0] c;
    if ($urandom_range(0, 5) == 0) begin
      c = 8'($urandom_range(1, 255));
      if (c == CHAR_CR || c == CHAR_LF) c = 8'hA5;
    end else begin
      c = 8'($urandom_range(33, 126));
    end
    return c;
  endfunction

  // per-phase settings, extremes on the first few phases
  task automatic load_phase_config(input int p);
    logic [5:0]          klen;
    logic [7:0]          lim;
    logic [KEY_BITS-1:0] key;
    logic [63:0]         data;
    bit                  wild;
    int                  used;
    case (p)
      0: klen = 6'd1;
      1: klen = 6'd32;
      2: klen = 6'd0;
      3: klen = 6'd63;
      4: klen = 6'd33;
      default: klen = 6'($urandom_range(2, 10));
    endcase
    case (p)
      0, 3, 5: lim = 8'd255;
      1: lim = 8'd0;
      2: lim = 8'd1;
      default: lim = 8'($urandom_range(1, 12));
    endcase
    wild = ($urandom_range(0, 3) == 0);
    used = (klen > KEY_MAX_BYTES) ? KEY_MAX_BYTES : klen;
    for (int i = 0; i < KEY_MAX_BYTES; i++) begin
      if (i >= used) key[i*8 +: 8] = 8'($urandom_range(0, 255));
      else if (wild) key[i*8 +: 8] = 8'($urandom_range(1, 255));
      else begin
        key[i*8 +: 8] = 8'($urandom_range(33, 126));
        if (key[i*8 +: 8] == CHAR_COLON) key[i*8 +: 8] = 8'h4B;
      end
    end
    data = {$urandom, $urandom};
    data[7:0] = lim;
    reg_write(REG_VALUE_LIMIT, data);
    reg_write(REG_KEY_BYTES_A, key[0   +: 64]);
    reg_write(REG_KEY_BYTES_B, key[64  +: 64]);
    reg_write(REG_KEY_BYTES_C, key[128 +: 64]);
    reg_write(REG_KEY_BYTES_D, key[192 +: 64]);
    data = {$urandom, $urandom};
    data[5:0] = klen;
    reg_write(REG_KEY_LENGTH, data);
    if ($urandom_range(0, 1) == 0)
      reg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom, $urandom});
  endtask

  // random header block: a few lines, mostly one carrying the key
  task automatic send_header(input int long_value);
    int unsigned klen, n_lines, key_at, vlen, len, pre;
    klen    = sb.active_len();
    n_lines = $urandom_range(1, 4);
    key_at  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, n_lines - 1) : n_lines;
    for (int i = 0; i < n_lines; i++) begin
      if (i == key_at) begin
        for (int j = 0; j < klen; j++) text_q.push_back(sb.key_bytes[j*8 +: 8]);
        text_q.push_back(CHAR_COLON);
        if ($urandom_range(0, 2) != 0) text_q.push_back(CHAR_SPACE);
        vlen = (long_value != 0) ? long_value
             : $urandom_range(0, (sb.limit < 14) ? sb.limit + 2 : 16);
        for (int j = 0; j < vlen; j++) text_q.push_back(value_char());
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            len = $urandom_range(0, 10);
            for (int j = 0; j < len; j++) text_q.push_back(noise_char());
          end
          1: begin
            // key prefix that breaks off
            pre = (klen == 0) ? 0 : $urandom_range(0, klen - 1);
            for (int j = 0; j < pre; j++) text_q.push_back(sb.key_bytes[j*8 +: 8]);
            text_q.push_back(noise_char());
            text_q.push_back(CHAR_COLON);
            text_q.push_back(noise_char());
          end
          2: begin
            // whole key without the colon
            for (int j = 0; j < klen; j++) text_q.push_back(sb.key_bytes[j*8 +: 8]);
            text_q.push_back(8'h3D);
            text_q.push_back(noise_char());
          end
          default: begin
            len = $urandom_range(1, 8);
            for (int j = 0; j < len; j++) text_q.push_back(8'($urandom_range(1, 255)));
          end
        endcase
      end
      // line end, sometimes broken, sometimes missing on the final line
      if (i != n_lines - 1 || $urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 5))
          0, 1, 2: begin
            text_q.push_back(CHAR_CR);
            text_q.push_back(CHAR_LF);
          end
          3, 4: text_q.push_back(CHAR_LF);
          default: text_q.push_back(CHAR_CR);
        endcase
      end
    end
    if (text_q.size() == 0) text_q.push_back(noise_char());
    send_text();
  endtask

  // main sequence
  initial begin
    int start;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: one-byte key of zero, zero bytes in key and value
    text_q = {8'h00, CHAR_COLON, 8'h00, 8'h5A, CHAR_CR, 8'h71};
    send_text();
    drain();

    // key "Ab", limit 3: limit reached mid-value, then colon on the last byte
    reg_write(REG_KEY_LENGTH, 64'd2);
    reg_write(REG_KEY_BYTES_A, 64'h0000_0000_0000_6241);
    reg_write(REG_VALUE_LIMIT, 64'd3);
    text_q = {8'h41, 8'h62, CHAR_COLON, CHAR_SPACE, 8'h78, 8'h79, 8'h7A, 8'h71};
    send_text();
    text_q = {8'h41, 8'h7A, CHAR_LF, 8'h41, 8'h62, CHAR_COLON};
    send_text();
    drain();

    // empty key with zero limit, spare indexes, then a miss
    reg_write(REG_KEY_LENGTH, 64'd0);
    reg_write(REG_VALUE_LIMIT, 64'd0);
    reg_write(REG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_write(REG_SPARE_HI, 64'h0123_4567_89AB_CDEF);
    text_q = {CHAR_COLON, 8'hFF};
    send_text();
    text_q = {8'h80, CHAR_LF};
    send_text();
    drain();

    // limit reached on the last byte
    reg_write(REG_VALUE_LIMIT, 64'd2);
    text_q = {CHAR_COLON, 8'h63, 8'h64};
    send_text();
    drain();

    // random phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      load_phase_config(p);
      if (p == 4) hold_req = 1'b1;
      if (p == 5) send_header(LONG_VALUE);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        send_header(0);
        if ($urandom_range(0, 11) == 0) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    sb.finish_check();
    if (sb.errors == 0)
      $display("header_field_extractor_top test passed");
    else
      $display("header_field_extractor_top test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/hfe_pkg.sv
hw/rtl/hfe_scan.sv
hw/rtl/header_field_extractor_top.sv
tb/header_field_extractor_top_tb.sv
